>>> sv/chi_pkg.sv
// Package for the two-table cuckoo hash insert block.
// Holds table geometry, key and index types, codes and slot hash functions.
// Depends on nothing; used by chi_table and cuckoo_hash_insert.
package chi_pkg;

  localparam int TableSize = 16;
  localparam int KeyBits   = 32;
  localparam int IdxBits   = $clog2(TableSize);
  localparam int KickBits  = 8;

  typedef logic [KeyBits-1:0]  key_t;
  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [KickBits-1:0] kick_t;

  localparam kick_t MaxKicksReset = kick_t'(16);

  // Result codes
  typedef enum logic [1:0] {
    STATUS_PLACED = 2'd0,
    STATUS_DUP    = 2'd1,
    STATUS_LIMIT  = 2'd2
  } status_e;

  // Insertion sequencer
  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    FIRST,
    SECOND,
    FINISH
  } state_e;

  // Write port of one table
  typedef struct packed {
    logic en;
    idx_t idx;
    key_t key;
  } wr_t;

  function automatic idx_t slot_one(key_t k);
    slot_one = idx_t'(k % TableSize);
  endfunction

  function automatic idx_t slot_two(key_t k);
    slot_two = idx_t'((k / TableSize) % TableSize);
  endfunction

endpackage

>>> sv/chi_table.sv
// One cuckoo hash table: key store with per-slot valid bits.
// One read and one write address per cycle; the key store has no reset.
// Depends on chi_pkg.
module chi_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  chi_pkg::idx_t rd_idx_i,
  output chi_pkg::key_t rd_key_o,
  output logic          rd_valid_o,
  input  chi_pkg::wr_t  wr_i
);

  chi_pkg::key_t                  keys_q [chi_pkg::TableSize];
  logic [chi_pkg::TableSize-1:0]  valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      keys_q[wr_i.idx] <= wr_i.key;
    end
  end

  assign rd_key_o   = keys_q[rd_idx_i];
  assign rd_valid_o = valid_q[rd_idx_i];

endmodule

>>> sv/cuckoo_hash_insert.sv
// Top level of the two-table cuckoo hash insert block.
// Holds the insertion sequencer, the config register and the result register.
// Depends on chi_pkg and chi_table.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------
//  request  | in        | in_valid_i / in_stall_o  | key_i
//  result   | out       | out_valid_o / out_stall_i| status_o, kicks_used_o, leftover_key_o
//  config   | in        | cfg_we_i                 | cfg_data_i (max_kicks)
//
// A request is taken in the idle state, then passes one duplicate check, F table-one
// steps, S table-two steps and one finish step before the next accept. A key that lands
// straight in table one needs one table-one step, a duplicate none, and each kick adds
// one table-one and one table-two step. The result is registered from the finish step.
// Reset clears the valid bits of both tables, max_kicks to 16 and all handshakes.
// A stalled result holds in the output register; finish waits while it is full and stalled.
module cuckoo_hash_insert (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [31:0]            key_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [7:0]             kicks_used_o,
  output logic [31:0]            leftover_key_o,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_data_i
);

  chi_pkg::state_e  state_q, state_d;
  chi_pkg::key_t    cur_q, cur_d;         // key being placed or moved
  chi_pkg::kick_t   kick_q, kick_d;
  chi_pkg::kick_t   max_q;
  chi_pkg::status_e res_status_q, res_status_d;
  chi_pkg::kick_t   res_kicks_q, res_kicks_d;
  chi_pkg::key_t    res_left_q, res_left_d;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  chi_pkg::status_e out_status_q;
  chi_pkg::kick_t   out_kicks_q;
  chi_pkg::key_t    out_left_q;

  chi_pkg::idx_t    idx1, idx2;
  chi_pkg::key_t    k1, k2;
  logic             v1, v2;
  chi_pkg::wr_t     wr1, wr2;
  chi_pkg::kick_t   kick_inc;
  logic             in_accept;

  // Both tables are always addressed by the current key's own slot
  assign idx1 = chi_pkg::slot_one(cur_q);
  assign idx2 = chi_pkg::slot_two(cur_q);

  chi_table u_first (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx1),
    .rd_key_o   (k1),
    .rd_valid_o (v1),
    .wr_i       (wr1)
  );

  chi_table u_second (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx2),
    .rd_key_o   (k2),
    .rd_valid_o (v2),
    .wr_i       (wr2)
  );

  assign in_stall_o = (state_q != chi_pkg::IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign kick_inc   = kick_q + chi_pkg::kick_t'(1);

  // Sequencer: check, then alternate table-one and table-two steps
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    kick_d       = kick_q;
    res_status_d = res_status_q;
    res_kicks_d  = res_kicks_q;
    res_left_d   = res_left_q;
    out_load     = 1'b0;
    wr1          = '{en: 1'b0, idx: idx1, key: cur_q};
    wr2          = '{en: 1'b0, idx: idx2, key: cur_q};

    unique case (state_q)
      chi_pkg::IDLE: begin
        if (in_accept) begin
          cur_d   = key_i;
          kick_d  = '0;
          state_d = chi_pkg::CHECK;
        end
      end
      chi_pkg::CHECK: begin
        // Duplicate if the key sits in either of its candidate slots
        if ((v1 && (k1 == cur_q)) || (v2 && (k2 == cur_q))) begin
          res_status_d = chi_pkg::STATUS_DUP;
          res_kicks_d  = '0;
          res_left_d   = '0;
          state_d      = chi_pkg::FINISH;
        end else begin
          state_d = chi_pkg::FIRST;
        end
      end
      chi_pkg::FIRST: begin
        // Take the table-one slot; carry any occupant on to table two
        wr1.en = 1'b1;
        if (!v1) begin
          res_status_d = chi_pkg::STATUS_PLACED;
          res_kicks_d  = kick_q;
          res_left_d   = '0;
          state_d      = chi_pkg::FINISH;
        end else begin
          cur_d   = k1;
          state_d = chi_pkg::SECOND;
        end
      end
      chi_pkg::SECOND: begin
        wr2.en = 1'b1;
        if (!v2) begin
          res_status_d = chi_pkg::STATUS_PLACED;
          res_kicks_d  = kick_q;
          res_left_d   = '0;
          state_d      = chi_pkg::FINISH;
        end else begin
          // Kick: the old table-two occupant restarts at table one
          kick_d = kick_inc;
          cur_d  = k2;
          if (kick_inc >= max_q) begin
            res_status_d = chi_pkg::STATUS_LIMIT;
            res_kicks_d  = kick_inc;
            res_left_d   = k2;
            state_d      = chi_pkg::FINISH;
          end else begin
            state_d = chi_pkg::FIRST;
          end
        end
      end
      chi_pkg::FINISH: begin
        // Hold the result until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = chi_pkg::IDLE;
        end
      end
      default: state_d = chi_pkg::IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chi_pkg::IDLE;
      kick_q      <= '0;
      max_q       <= chi_pkg::MaxKicksReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kick_q      <= kick_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    res_status_q <= res_status_d;
    res_kicks_q  <= res_kicks_d;
    res_left_q   <= res_left_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_kicks_q  <= res_kicks_q;
      out_left_q   <= res_left_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign kicks_used_o   = out_kicks_q;
  assign leftover_key_o = out_left_q;

  // An accepted request always starts with the duplicate check
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == chi_pkg::CHECK))
    else $error("accepted request did not enter the duplicate check");

  // A new result is only ever loaded from the finish step
  a_rose_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == chi_pkg::FINISH))
    else $error("result appeared outside the finish step");

  // Only a failed insertion reports a homeless key
  a_left_only_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != chi_pkg::STATUS_LIMIT)) |-> (leftover_key_o == '0))
    else $error("leftover key reported without kick limit");

  // A duplicate moves nothing
  a_dup_no_kicks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == chi_pkg::STATUS_DUP)) |-> (kicks_used_o == '0))
    else $error("duplicate result with nonzero kicks");

endmodule

>>> tb/cuckoo_insert_checker.sv
// Checker for the cuckoo hash insert block: watches the request, result and config ports,
// keeps its own copy of both tables and compares every result with the predicted one.
// Depends on chi_pkg for key, index, kick and status types.
module cuckoo_insert_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] key_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  kicks_used_i,
  input  logic [31:0] leftover_key_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  output int          mismatch_count_o,
  output int          awaiting_o
);

  typedef struct packed {
    chi_pkg::status_e status;
    chi_pkg::kick_t   kicks;
    chi_pkg::key_t    leftover;
  } insert_result_t;

  insert_result_t pending_results[$];

  chi_pkg::key_t  home_key  [chi_pkg::TableSize];
  logic           home_used [chi_pkg::TableSize];
  chi_pkg::key_t  alt_key   [chi_pkg::TableSize];
  logic           alt_used  [chi_pkg::TableSize];
  chi_pkg::kick_t kick_limit;
  int             mismatches;

  function automatic chi_pkg::idx_t first_slot(chi_pkg::key_t k);
    return chi_pkg::idx_t'(k % chi_pkg::TableSize);
  endfunction

  function automatic chi_pkg::idx_t second_slot(chi_pkg::key_t k);
    return chi_pkg::idx_t'((k / chi_pkg::TableSize) % chi_pkg::TableSize);
  endfunction

  // Walk the kick chain on the shadow tables and return the outcome.
  function automatic insert_result_t predict_insert(chi_pkg::key_t k);
    chi_pkg::key_t  cur;
    chi_pkg::key_t  moved;
    chi_pkg::key_t  homeless;
    chi_pkg::idx_t  a;
    chi_pkg::idx_t  b;
    logic           done;
    insert_result_t res;
    cur          = k;
    res.status   = chi_pkg::STATUS_PLACED;
    res.kicks    = '0;
    res.leftover = '0;
    a = first_slot(cur);
    b = second_slot(cur);
    if ((home_used[a] && home_key[a] == cur) || (alt_used[b] && alt_key[b] == cur)) begin
      res.status = chi_pkg::STATUS_DUP;
    end else begin
      done = 1'b0;
      while (!done) begin
        a = first_slot(cur);
        if (!home_used[a]) begin
          home_key[a]  = cur;
          home_used[a] = 1'b1;
          done         = 1'b1;
        end else begin
          moved       = home_key[a];
          home_key[a] = cur;
          b           = second_slot(moved);
          if (!alt_used[b]) begin
            alt_key[b]  = moved;
            alt_used[b] = 1'b1;
            done        = 1'b1;
          end else begin
            homeless   = alt_key[b];
            alt_key[b] = moved;
            res.kicks  = res.kicks + chi_pkg::kick_t'(1);
            // a zero limit trips on the first kick, same as one
            if (res.kicks >= kick_limit) begin
              res.status   = chi_pkg::STATUS_LIMIT;
              res.leftover = homeless;
              done         = 1'b1;
            end else begin
              cur = homeless;
            end
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    insert_result_t oldest;
    insert_result_t predicted;
    if (!rst_ni) begin
      for (int i = 0; i < chi_pkg::TableSize; i++) begin
        home_used[i] = 1'b0;
        alt_used[i]  = 1'b0;
      end
      kick_limit = chi_pkg::MaxKicksReset;
      mismatches = 0;
      pending_results.delete();
      mismatch_count_o <= 0;
      awaiting_o       <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: status %0d kicks %0d leftover %0h",
                 status_i, kicks_used_i, leftover_key_i);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, status_i);
            mismatches++;
          end
          if (kicks_used_i !== oldest.kicks) begin
            $error("kicks_used: expected %0d, actual %0d", oldest.kicks, kicks_used_i);
            mismatches++;
          end
          if (leftover_key_i !== oldest.leftover) begin
            $error("leftover_key: expected %0h, actual %0h", oldest.leftover, leftover_key_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predicted       = predict_insert(key_i);
        pending_results = {pending_results, predicted};
      end
      if (cfg_we_i) begin
        kick_limit = cfg_data_i;
      end
      mismatch_count_o <= mismatches;
      awaiting_o       <= pending_results.size();
    end
  end

endmodule

>>> tb/cuckoo_hash_insert_test.sv
// Top of the cuckoo hash insert testbench: clock, reset, request and config stimulus,
// random result back-pressure and the final verdict.
// Depends on chi_pkg, cuckoo_hash_insert and cuckoo_insert_checker.
module cuckoo_hash_insert_test;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [31:0] key_i       = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_data_i  = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [7:0]  kicks_used_o;
  logic [31:0] leftover_key_o;

  int   mismatch_count;
  int   awaiting;

  // calm suppresses request gaps and result stalls for a whole phase
  bit   calm       = 1'b0;
  int   stall_left = 0;
  chi_pkg::key_t sent_keys[$];

  cuckoo_hash_insert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .kicks_used_o   (kicks_used_o),
    .leftover_key_o (leftover_key_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  cuckoo_insert_checker insert_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .key_i            (key_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .kicks_used_i     (kicks_used_o),
    .leftover_key_i   (leftover_key_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .awaiting_o       (awaiting)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: several times the slowest legal run, where every request walks a
  // 255-kick chain while the result side sits in its longest stall.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result back-pressure: hold the stall level for a random run of cycles.
  // Mostly open runs and short stalls, now and then a long stall.
  always @(posedge clk_i) begin : stall_gen
    int roll;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (calm) begin
      out_stall_i <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall_i <= 1'b0;
        stall_left  <= $urandom_range(0, 11);
      end else if (roll < 93) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(9, 39);
      end
    end
  end

  // Idle cycles before the next request: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) begin
      return 0;
    end
    if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Present one request and hold it until the block takes it. Valid is only
  // dropped ahead of a gap, so back-to-back requests keep it high.
  task automatic send_key(input chi_pkg::key_t k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i      <= k;
    sent_keys  = {sent_keys, k};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every predicted result has come back. The extra
  // edge lets the checker publish the count for the request taken last.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  // Write max_kicks with the block idle; a few spare cycles let the result
  // register drain before the write.
  task automatic write_kick_limit(input chi_pkg::kick_t limit);
    settle();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Random key: repeats of earlier keys (duplicates or re-inserts of evicted
  // keys), keys that share both slots with an earlier one, extremes, and fresh
  // random keys.
  function automatic chi_pkg::key_t random_key();
    int            roll;
    chi_pkg::key_t k;
    roll = $urandom_range(0, 99);
    if (roll < 30 && sent_keys.size() > 0) begin
      k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    end else if (roll < 45 && sent_keys.size() > 0) begin
      k      = chi_pkg::key_t'($urandom);
      k[7:0] = sent_keys[$urandom_range(0, sent_keys.size() - 1)][7:0];
    end else if (roll < 50) begin
      case ($urandom_range(0, 3))
        0:       k = '0;
        1:       k = '1;
        2:       k = 32'h8000_0000;
        default: k = 32'h0000_0001;
      endcase
    end else begin
      k = chi_pkg::key_t'($urandom);
    end
    return k;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset limit of 16: empty slots, duplicates found in either
    // table, extremes of the key, and a crowd of keys with low nibble zero so that
    // table-one collisions turn into kick chains.
    send_key(32'h0000_0000);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0010);
    send_key(32'h0000_0010);
    send_key(32'h0000_0000);
    send_key(32'h0000_0020);
    send_key(32'h0000_0100);
    send_key(32'h0000_0110);
    send_key(32'h0000_01F0);
    send_key(32'h8000_0000);
    send_key(32'h7FFF_FFFF);

    // Limit of one: fail at the first kick.
    write_kick_limit(chi_pkg::kick_t'(1));
    send_key(32'h0000_0200);
    send_key(32'h0000_0300);
    send_key(32'h0000_0210);

    // Zero limit lies outside the legal range and must act like one.
    write_kick_limit(chi_pkg::kick_t'(0));
    send_key(32'h0000_0400);
    send_key(32'h0000_0500);

    // Widest limit: three keys fighting over two slots cycle until the limit.
    write_kick_limit(chi_pkg::kick_t'(255));
    send_key(32'h0000_0600);
    send_key(32'hA5A5_A5A5);

    // Random phases, each behind a fresh limit; every write waits for the
    // block to go quiet, which also pauses the sender until all results are in.
    for (int phase = 0; phase < 11; phase++) begin
      chi_pkg::kick_t limit;
      case (phase)
        0:       limit = chi_pkg::kick_t'(2);
        3:       limit = chi_pkg::kick_t'(255);
        5:       limit = chi_pkg::kick_t'(1);
        8:       limit = chi_pkg::kick_t'($urandom_range(1, 255));
        default: limit = chi_pkg::kick_t'($urandom_range(1, 12));
      endcase
      write_kick_limit(limit);
      calm = (phase % 4 == 2);
      repeat (50) send_key(random_key());
    end
    calm = 1'b0;

    // Drain, then leave room for a stray result from the longest chain.
    settle();
    repeat (520) @(posedge clk_i);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
